>>> rtl/lctw_pkg.sv
// Shared types, constants and helpers for the character LCD text front end.
package lctw_pkg;

  // Display geometry defaults
  localparam int unsigned COLS_DEF   = 16;
  localparam int unsigned ROWS_DEF   = 4;
  localparam int unsigned QDEPTH_DEF = 2;

  // Row index always fits four rows
  localparam int unsigned ROW_W = 2;

  // Configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_ROW0_BASE = 2'd0,
    REG_ROW1_BASE = 2'd1,
    REG_ROW2_BASE = 2'd2,
    REG_ROW3_BASE = 2'd3
  } lctw_reg_e;

  localparam logic [6:0] ROW0_BASE_RST = 7'h00;
  localparam logic [6:0] ROW1_BASE_RST = 7'h40;
  localparam logic [6:0] ROW2_BASE_RST = 7'h10;
  localparam logic [6:0] ROW3_BASE_RST = 7'h50;

  // Controller command bytes
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_RET_HOME  = 8'h02;
  localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;

  // Text operation codes
  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_GOTO  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_HOME  = 3'd3,
    CMD_GLYPH = 3'd4
  } lctw_cmd_e;

  // Input request
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_byte;
    logic [7:0] target_row;
    logic [7:0] target_col;
    logic [2:0] glyph;
    logic [2:0] glyph_line;
    logic [4:0] pattern;
  } lctw_in_t;

  // Output request
  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } lctw_out_t;

  // One controller write
  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
  } lctw_wr_t;

  // Classified job: up to three writes, last_idx is the index of the final one
  typedef struct packed {
    logic [1:0] last_idx;
    lctw_wr_t   wr2;
    lctw_wr_t   wr1;
    lctw_wr_t   wr0;
  } lctw_job_t;

  // Row base addresses
  typedef struct packed {
    logic [6:0] row0_base;
    logic [6:0] row1_base;
    logic [6:0] row2_base;
    logic [6:0] row3_base;
  } lctw_cfg_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } lctw_qstat_t;

  function automatic logic [6:0] row_base_sel(lctw_cfg_t cfg, logic [ROW_W-1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = cfg.row0_base;
      2'd1:    base = cfg.row1_base;
      2'd2:    base = cfg.row2_base;
      default: base = cfg.row3_base;
    endcase
    return base;
  endfunction

endpackage

>>> rtl/lcd_text_cursor_wrap.sv
// Top level of the character LCD text front end with cursor and line wrap.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o  in_req_i  (lctw_in_t)
//   out       source     out_valid_o/out_stall_i out_req_o (lctw_out_t)
//   cfg       sink       APB psel/penable/pready paddr, pwdata, prdata
//
// Each text operation becomes one to three LCD writes, one write per cycle
// from the back part while the output is not stalled.
// The front takes a new request every cycle while the job queue has room.
// First write passes through the job queue, then the output register.
// Reset clears the cursor, the queue and the output valid; row bases reload.
// A stall on the output holds the write and fills the queue, then stalls in.
module lcd_text_cursor_wrap #(
  parameter int unsigned COLS   = lctw_pkg::COLS_DEF,
  parameter int unsigned ROWS   = lctw_pkg::ROWS_DEF,
  parameter int unsigned QDEPTH = lctw_pkg::QDEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lctw_pkg::lctw_in_t            in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lctw_pkg::lctw_out_t           out_req_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lctw_pkg::APB_AW-1:0]   paddr,
  input  logic [lctw_pkg::APB_DW-1:0]   pwdata,
  output logic [lctw_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import lctw_pkg::*;

  lctw_cfg_t   cfg_q;
  lctw_job_t   push_job, head_job;
  lctw_qstat_t qstat;
  logic        push, pop;
  logic        cfg_wr;
  lctw_reg_e   reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = lctw_reg_e'(paddr[3:2]);

  // Row base registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row0_base <= ROW0_BASE_RST;
      cfg_q.row1_base <= ROW1_BASE_RST;
      cfg_q.row2_base <= ROW2_BASE_RST;
      cfg_q.row3_base <= ROW3_BASE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ROW0_BASE: cfg_q.row0_base <= pwdata[6:0];
        REG_ROW1_BASE: cfg_q.row1_base <= pwdata[6:0];
        REG_ROW2_BASE: cfg_q.row2_base <= pwdata[6:0];
        REG_ROW3_BASE: cfg_q.row3_base <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_sel)
      REG_ROW0_BASE: prdata = APB_DW'(cfg_q.row0_base);
      REG_ROW1_BASE: prdata = APB_DW'(cfg_q.row1_base);
      REG_ROW2_BASE: prdata = APB_DW'(cfg_q.row2_base);
      REG_ROW3_BASE: prdata = APB_DW'(cfg_q.row3_base);
      default:       prdata = '0;
    endcase
  end

  lctw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .job_o      (push_job)
  );

  lctw_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (qstat)
  );

  lctw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

>>> rtl/lctw_front.sv
// Front part: accepts text operations, tracks the cursor and builds write jobs.
module lctw_front #(
  parameter int unsigned COLS = lctw_pkg::COLS_DEF,
  parameter int unsigned ROWS = lctw_pkg::ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lctw_pkg::lctw_in_t  in_req_i,
  input  lctw_pkg::lctw_cfg_t cfg_i,
  input  lctw_pkg::lctw_qstat_t qstat_i,
  output logic                push_o,
  output lctw_pkg::lctw_job_t job_o
);
  import lctw_pkg::*;

  localparam int unsigned CW = $clog2(COLS + 1);

  logic [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic             accept;
  logic             row_full;
  logic [ROW_W-1:0] wrap_row;
  logic [ROW_W-1:0] row_cl;
  logic [CW-1:0]    col_cl;
  logic [ROW_W-1:0] a_row;
  logic [CW-1:0]    a_col;
  logic [7:0]       addr_byte;
  logic             known;
  lctw_cmd_e        cmd;

  assign cmd        = lctw_cmd_e'(in_req_i.cmd);
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept && known;

  // Cursor helpers
  assign row_full = (col_q >= CW'(COLS));
  assign wrap_row = ((3'(row_q) + 3'd1) >= 3'(ROWS)) ? '0 : row_q + 2'd1;
  assign row_cl   = (in_req_i.target_row > 8'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                         : in_req_i.target_row[ROW_W-1:0];
  assign col_cl   = (in_req_i.target_col > 8'(COLS - 1)) ? CW'(COLS - 1)
                                                         : in_req_i.target_col[CW-1:0];

  // Pick the one position whose address this operation needs
  always_comb begin
    a_row = row_q;
    a_col = col_q;
    unique case (cmd)
      CMD_PUT: begin
        a_row = wrap_row;
        a_col = '0;
      end
      CMD_GOTO: begin
        a_row = row_cl;
        a_col = col_cl;
      end
      default: ;
    endcase
  end

  assign addr_byte = LCD_SET_DDRAM |
                     {1'b0, row_base_sel(cfg_i, a_row) + 7'(a_col)};

  // Classify and build the job, next cursor
  always_comb begin
    job_o = '0;
    known = 1'b1;
    row_d = row_q;
    col_d = col_q;
    unique case (cmd)
      CMD_PUT: begin
        if (row_full) begin
          job_o.last_idx = 2'd1;
          job_o.wr0      = '{is_data: 1'b0, lcd_byte: addr_byte};
          job_o.wr1      = '{is_data: 1'b1, lcd_byte: in_req_i.char_byte};
          row_d          = wrap_row;
          col_d          = CW'(1);
        end else begin
          job_o.last_idx = 2'd0;
          job_o.wr0      = '{is_data: 1'b1, lcd_byte: in_req_i.char_byte};
          col_d          = col_q + CW'(1);
        end
      end
      CMD_GOTO: begin
        job_o.wr0 = '{is_data: 1'b0, lcd_byte: addr_byte};
        row_d     = row_cl;
        col_d     = col_cl;
      end
      CMD_CLEAR: begin
        job_o.wr0 = '{is_data: 1'b0, lcd_byte: LCD_CLEAR};
        row_d     = '0;
        col_d     = '0;
      end
      CMD_HOME: begin
        job_o.wr0 = '{is_data: 1'b0, lcd_byte: LCD_RET_HOME};
        row_d     = '0;
        col_d     = '0;
      end
      CMD_GLYPH: begin
        job_o.last_idx = 2'd2;
        job_o.wr0      = '{is_data: 1'b0,
                           lcd_byte: LCD_SET_CGRAM |
                                     {2'b00, in_req_i.glyph, in_req_i.glyph_line}};
        job_o.wr1      = '{is_data: 1'b1, lcd_byte: {3'b000, in_req_i.pattern}};
        job_o.wr2      = '{is_data: 1'b0, lcd_byte: addr_byte};
      end
      default: known = 1'b0;
    endcase
  end

  // Cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

>>> rtl/lctw_queue.sv
// Short job queue between the front and back parts.
module lctw_queue #(
  parameter int unsigned DEPTH = lctw_pkg::QDEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lctw_pkg::lctw_job_t   job_i,
  input  logic                  pop_i,
  output lctw_pkg::lctw_job_t   job_o,
  output lctw_pkg::lctw_qstat_t stat_o
);
  import lctw_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  lctw_job_t     slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == NW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

>>> rtl/lctw_back.sv
// Back part: steps through a job's writes into the output register.
module lctw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lctw_pkg::lctw_job_t   job_i,
  input  lctw_pkg::lctw_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lctw_pkg::lctw_out_t   out_req_o
);
  import lctw_pkg::*;

  logic       out_valid_q;
  lctw_out_t  out_q;
  logic [1:0] idx_q;
  logic       load;
  logic       is_last;
  lctw_wr_t   cur;

  // Current write of the head job
  always_comb begin
    case (idx_q)
      2'd0:    cur = job_i.wr0;
      2'd1:    cur = job_i.wr1;
      default: cur = job_i.wr2;
    endcase
  end

  assign is_last = (idx_q == job_i.last_idx);
  assign load    = !qstat_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && is_last;

  // Write index within the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (load) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= '{is_data: cur.is_data, lcd_byte: cur.lcd_byte, last: is_last};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> rtl/lctw_checker.sv
// Port-level checks for the LCD text front end, bound to the top level.
module lctw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lctw_pkg::lctw_out_t out_req_o,
  input logic                pready
);
  import lctw_pkg::*;

  // A stalled write holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled LCD write changed");

  // The port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // A non-final data byte is always a glyph pattern line
  a_mid_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.is_data && !out_req_o.last |->
      out_req_o.lcd_byte[7:5] == 3'b000)
    else $error("non-final data byte wider than a pattern line");

  // A non-final command is a set-address command
  a_mid_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.is_data && !out_req_o.last |->
      out_req_o.lcd_byte[7] || out_req_o.lcd_byte[6])
    else $error("non-final command is not an address command");

  // The rest of a job follows without a gap
  a_job_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_req_o.last |=> out_valid_o)
    else $error("gap inside a multi-write request");

endmodule

bind lcd_text_cursor_wrap lctw_checker u_lctw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o),
  .pready      (pready)
);
